>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define VTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define VTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/vtd_pkg.sv
// ----------------------------------------------------------------------------
// vtd_pkg
// Types, widths and defaults shared by the vertex dedup core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vtd_pkg;

    localparam int FIELD_W     = 24;
    localparam int VERTEX_ID_W = 12;
    localparam int DISTINCT_W  = 13;
    localparam int CORNERS_W   = 16;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int INDEX_BITS_DEF  = 24;

    localparam logic [CORNERS_W-1:0] CORNER_MAX = {CORNERS_W{1'b1}};

    typedef struct packed {
        logic               first_of_mesh;
        logic [FIELD_W-1:0] pos_index;
        logic [FIELD_W-1:0] tex_index;
        logic [FIELD_W-1:0] nrm_index;
    } in_word_t;

    typedef struct packed {
        logic [VERTEX_ID_W-1:0] vertex_id;
        logic                   is_new;
        logic                   table_full;
        logic [DISTINCT_W-1:0]  distinct_count;
        logic [CORNERS_W-1:0]   corners_seen;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } vtd_state_t;

endpackage

`default_nettype wire

>>> hdl/vtd_stream_if.sv
// ----------------------------------------------------------------------------
// vtd_stream_if
// Valid/ready stream carrying one word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vtd_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/vtd_ram.sv
// ----------------------------------------------------------------------------
// vtd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/vertex_triple_dedup_core.sv
// ----------------------------------------------------------------------------
// vertex_triple_dedup_core
// Face-corner index triple dedup against a per-mesh table of distinct triples.
// ----------------------------------------------------------------------------
// Usage:
//   corner (sink): one word per face corner, holding first_of_mesh and the
//     position / texture / normal indices. Each index keeps its low
//     INDEX_BITS bits. first_of_mesh empties the table and the corner count.
//   vertex (source): one word per corner: vertex_id, is_new, table_full,
//     distinct_count and corners_seen.
//   A corner is compared with the stored triples of its mesh from entry 0
//     up to the first match or the last stored entry; an empty table
//     skips the scan. The scan loop reads one table entry per cycle
//     through the single read port of the triple RAM and compares it in
//     the following cycle.
//   One corner is in work at a time. The next corner is taken as soon as the
//     previous result sits in the output register, even if it is not yet
//     taken; a stalled receiver holds only the finish step of the next word.
//   Reset clears the stored count and corner count; the triple RAM is not
//     cleared, since entries at or above the count are never used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_triple_dedup_core
    import vtd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    vtd_stream_if.sink   corner,
    vtd_stream_if.source vertex
);

    // Stored key width: indices narrower than the field are masked down.
    localparam int KEY_W   = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
    localparam int ENTRY_W = 3 * KEY_W;
    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    vtd_state_t state_reg, state_next;

    logic [ENTRY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CORNERS_W-1:0] corners_reg, corners_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic                 hit_reg, hit_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_word_reg, out_word_next;

    logic               corner_acc;
    logic [CNT_W-1:0]   count_eff;
    logic [ENTRY_W-1:0] rd_data;
    logic               match;
    logic               last_entry;
    logic               out_free;
    logic               table_is_full;
    logic               wr_en;

    // ------------------------------------------------------------------------
    // Shared conditions
    // ------------------------------------------------------------------------
    assign corner_acc    = corner.valid && corner.ready;
    assign count_eff     = corner.data.first_of_mesh ? '0 : count_reg;
    assign match         = (rd_data == key_reg);
    // Entry under compare is the last stored one.
    assign last_entry    = ((CNT_W'(addr_reg) + CNT_W'(1)) >= count_reg);
    assign out_free      = !out_valid_reg || vertex.ready;
    assign table_is_full = (count_reg == FULL_COUNT);

    // Append on a miss that still fits, in the finish step. The next scan
    // starts only after this cycle, so reads never race the write.
    assign wr_en = (state_reg == ST_DONE) && out_free && !hit_reg && !table_is_full;

    vtd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_triples (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (key_reg),
        .rd_addr (addr_next),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (corner_acc)
                begin
                    // Empty table: nothing to scan.
                    state_next = (count_eff == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match || last_entry)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        key_next       = key_reg;
        count_next     = count_reg;
        corners_next   = corners_reg;
        addr_next      = addr_reg;
        hit_next       = hit_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !vertex.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (corner_acc)
                begin
                    key_next   = {corner.data.pos_index[KEY_W-1:0],
                                  corner.data.tex_index[KEY_W-1:0],
                                  corner.data.nrm_index[KEY_W-1:0]};
                    count_next = count_eff;
                    if (corner.data.first_of_mesh)
                    begin
                        corners_next = CORNERS_W'(1);
                    end
                    else if (corners_reg != CORNER_MAX)
                    begin
                        corners_next = corners_reg + CORNERS_W'(1);
                    end
                    addr_next = '0;
                    hit_next  = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // rd_data holds the entry at addr_reg.
                if (match)
                begin
                    hit_next = 1'b1;
                end
                else if (!last_entry)
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_word_next.corners_seen   = corners_reg;
                    out_word_next.is_new         = !hit_reg;
                    out_word_next.table_full     = !hit_reg && table_is_full;
                    out_word_next.distinct_count = DISTINCT_W'(count_reg);
                    if (hit_reg)
                    begin
                        out_word_next.vertex_id = VERTEX_ID_W'(addr_reg);
                    end
                    else if (table_is_full)
                    begin
                        out_word_next.vertex_id = '0;
                    end
                    else
                    begin
                        out_word_next.vertex_id      = VERTEX_ID_W'(count_reg);
                        count_next                   = count_reg + CNT_W'(1);
                        out_word_next.distinct_count = DISTINCT_W'(count_reg + CNT_W'(1));
                    end
                end
            end
            default:
            begin
                addr_next = '0;
            end
        endcase
    end

    assign corner.ready = (state_reg == ST_IDLE);
    assign vertex.valid = out_valid_reg;
    assign vertex.data  = out_word_reg;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            corners_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            corners_reg   <= corners_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        addr_reg     <= addr_next;
        hit_reg      <= hit_next;
        out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

>>> hdl/vtd_checker.sv
// ----------------------------------------------------------------------------
// vtd_checker
// Port-level checks for the vertex dedup core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vtd_checker
    import vtd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_word_t out_word
);

    // Corners accepted whose result word is not yet taken.
    logic [1:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `VTD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_word), "result word changed while stalled")
    `VTD_ASSERT(a_no_orphan, clk, rst_n, out_valid |-> pending_reg != 2'd0, "result word without an accepted corner")
    `VTD_ASSERT(a_depth, clk, rst_n, pending_reg != 2'd3, "more than two corners outstanding")
    `VTD_ASSERT(a_full_word, clk, rst_n, out_valid && out_word.table_full |-> out_word.is_new && out_word.vertex_id == '0, "full flag with bad id")
    `VTD_ASSERT(a_new_id, clk, rst_n, out_valid && out_word.is_new && !out_word.table_full |-> out_word.vertex_id == VERTEX_ID_W'(out_word.distinct_count - DISTINCT_W'(1)), "new vertex id not last stored")

endmodule

bind vertex_triple_dedup_core vtd_checker u_vtd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (corner.valid),
    .in_ready  (corner.ready),
    .out_valid (vertex.valid),
    .out_ready (vertex.ready),
    .out_word  (vertex.data)
);

`default_nettype wire

>>> bench/vertex_triple_dedup_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_triple_dedup_core_tb
// Self-checking bench for the face-corner triple dedup core. Corner words go
// in over a valid/ready stream and are predicted against a local copy of the
// per-mesh triple table. Each vertex word that comes out is checked against
// the oldest prediction. Covered: index extremes, mesh restarts, and random
// meshes with repeats and near-duplicates.
// ----------------------------------------------------------------------------

module vertex_triple_dedup_core_tb;
    import vtd_pkg::*;

    // Core runs at its default table size.
    localparam int TB_DEPTH      = TABLE_DEPTH_DEF;
    localparam int TB_INDEX_BITS = INDEX_BITS_DEF;

    localparam int     CLK_HALF         = 5;
    localparam int     RESET_CYCLES     = 4;
    localparam int     IDLE_MAX         = 19;
    localparam int     MAX_REPORTS      = 10;
    localparam int     RANDOM_IDLE_CNT  = 90;
    localparam int     RANDOM_BUSY_CNT  = 40;
    localparam int     POOL_MAX         = 40;
    // Worst case per word: a full scan, the longest sender gap and the
    // longest receiver stall. This is taken over every word, with wide margin.
    localparam longint CYCLE_LIMIT      = 12_000_000;

    localparam logic [FIELD_W-1:0] ALL_ONES = '1;
    localparam logic [FIELD_W-1:0] IDX_MASK =
        FIELD_W'((64'd1 << TB_INDEX_BITS) - 64'd1);

    typedef struct packed {
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] tex;
        logic [FIELD_W-1:0] nrm;
    } triple_t;

    logic clk = 1'b0;
    logic rst_n;

    vtd_stream_if #(.word_t(in_word_t))  corner_if ();
    vtd_stream_if #(.word_t(out_word_t)) vertex_if ();

    vertex_triple_dedup_core #(
        .TABLE_DEPTH (TB_DEPTH),
        .INDEX_BITS  (TB_INDEX_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .corner (corner_if),
        .vertex (vertex_if)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: distinct triples of the current mesh, the number
    // stored, and the saturating corner count.
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0]   seen_pos [TB_DEPTH];
    logic [FIELD_W-1:0]   seen_tex [TB_DEPTH];
    logic [FIELD_W-1:0]   seen_nrm [TB_DEPTH];
    int unsigned          seen_count   = 0;
    logic [CORNERS_W-1:0] corner_tally = '0;

    out_word_t expected_vertices[$];
    int        failures  = 0;
    bit        send_idle = 1'b1;
    bit        sink_idle = 1'b1;

    // Works out the vertex word for one accepted corner and updates the
    // local table the same way the core does.
    function automatic out_word_t dedup_predict(input in_word_t w);
        out_word_t          r;
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] t;
        logic [FIELD_W-1:0] n;
        bit                 hit;
        int unsigned        slot;
        int unsigned        k;
        p    = w.pos_index & IDX_MASK;
        t    = w.tex_index & IDX_MASK;
        n    = w.nrm_index & IDX_MASK;
        r    = '0;
        hit  = 1'b0;
        slot = 0;
        // Start of a new mesh: table and corner count are emptied first.
        if (w.first_of_mesh) begin
            seen_count   = 0;
            corner_tally = '0;
        end
        if (corner_tally < CORNER_MAX)
            corner_tally++;
        // First match wins, so a hit returns the oldest matching entry.
        for (k = 0; k < seen_count && !hit; k++) begin
            if (seen_pos[k] == p && seen_tex[k] == t && seen_nrm[k] == n) begin
                hit  = 1'b1;
                slot = k;
            end
        end
        if (!hit) begin
            r.is_new = 1'b1;
            if (seen_count < TB_DEPTH) begin
                seen_pos[seen_count] = p;
                seen_tex[seen_count] = t;
                seen_nrm[seen_count] = n;
                slot = seen_count;
                seen_count++;
            end else begin
                // Table full on a miss: nothing stored, id forced to zero.
                r.table_full = 1'b1;
                slot = 0;
            end
        end
        r.vertex_id      = VERTEX_ID_W'(slot);
        r.distinct_count = DISTINCT_W'(seen_count);
        r.corners_seen   = corner_tally;
        return r;
    endfunction

    function automatic in_word_t make_corner(input bit first, input triple_t tr);
        in_word_t w;
        w.first_of_mesh = first;
        w.pos_index     = tr.pos;
        w.tex_index     = tr.tex;
        w.nrm_index     = tr.nrm;
        return w;
    endfunction

    // Per field: mostly full-range random, sometimes an extreme.
    function automatic logic [FIELD_W-1:0] random_index();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ALL_ONES;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic triple_t random_triple();
        triple_t tr;
        tr.pos = random_index();
        tr.tex = random_index();
        tr.nrm = random_index();
        return tr;
    endfunction

    task automatic note_failure(input string what, input out_word_t want,
                                input out_word_t got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] %s: expected id=%0d new=%0b full=%0b distinct=%0d corners=%0d,",
                     $realtime, what, want.vertex_id, want.is_new, want.table_full,
                     want.distinct_count, want.corners_seen,
                     " got id=%0d new=%0b full=%0b distinct=%0d corners=%0d",
                     got.vertex_id, got.is_new, got.table_full,
                     got.distinct_count, got.corners_seen);
    endtask

    // Sends one corner word. Called at a falling edge and returns at a
    // falling edge with valid still high, so back-to-back words keep valid
    // up without a drop in between, unless a gap is drawn while send_idle is set.
    task automatic send_corner(input in_word_t w);
        int gap;
        if (send_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, IDLE_MAX);
            corner_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        corner_if.valid <= 1'b1;
        corner_if.data  <= w;
        @(posedge clk);
        while (!corner_if.ready)
            @(posedge clk);
        expected_vertices.push_back(dedup_predict(w));
        @(negedge clk);
    endtask

    // Drops valid and holds off until every predicted word has come out.
    task automatic drain_results();
        corner_if.valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Index extremes, single-field differences, and a mesh restart that
    // must forget triples of the previous mesh.
    task automatic test_directed_extremes();
        send_corner(make_corner(1'b1, '{'0, '0, '0}));
        send_corner(make_corner(1'b0, '{ALL_ONES, ALL_ONES, ALL_ONES}));
        send_corner(make_corner(1'b0, '{'0, '0, '0}));
        send_corner(make_corner(1'b0, '{ALL_ONES, ALL_ONES, ALL_ONES}));
        send_corner(make_corner(1'b0, '{ALL_ONES, '0, '0}));
        send_corner(make_corner(1'b0, '{'0, ALL_ONES, '0}));
        send_corner(make_corner(1'b0, '{'0, '0, ALL_ONES}));
        send_corner(make_corner(1'b0, '{24'hAAAAAA, 24'h555555, 24'hAAAAAA}));
        send_corner(make_corner(1'b1, '{ALL_ONES, ALL_ONES, ALL_ONES}));
        send_corner(make_corner(1'b0, '{'0, '0, '0}));
    endtask

    // Random meshes: each draws corners from a small pool of triples so hits
    // and misses mix. Near-duplicates differ in one field. A few words are
    // noise with a random restart flag. Halfway, the sender holds off until
    // every result is back.
    task automatic test_random_meshes(input int count);
        triple_t pool[$];
        triple_t tr;
        int      pool_size;
        int      mesh_len;
        int      sent;
        int      i;
        bit      first;
        sent = 0;
        while (sent < count) begin
            pool.delete();
            pool_size = $urandom_range(1, POOL_MAX);
            for (i = 0; i < pool_size; i++) begin
                if (i > 0 && $urandom_range(0, 3) == 0) begin
                    tr = pool[$urandom_range(0, i - 1)];
                    case ($urandom_range(0, 2))
                        0:       tr.pos = random_index();
                        1:       tr.tex = random_index();
                        default: tr.nrm = random_index();
                    endcase
                end else begin
                    tr = random_triple();
                end
                pool.push_back(tr);
            end
            mesh_len = $urandom_range(1, 30);
            for (i = 0; i < mesh_len && sent < count; i++) begin
                first = (i == 0);
                if ($urandom_range(0, 15) == 0) begin
                    tr    = random_triple();
                    first = $urandom_range(0, 1);
                end else begin
                    tr = pool[$urandom_range(0, pool_size - 1)];
                end
                send_corner(make_corner(first, tr));
                sent++;
                if (sent == count / 2)
                    drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready toggles in random bursts with stalls while sink_idle is
    // set, otherwise always ready.
    // ------------------------------------------------------------------
    initial begin : vertex_ready_drive
        int hold;
        bit level;
        hold            = 0;
        level           = 1'b0;
        vertex_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!sink_idle) begin
                level = 1'b1;
                hold  = 0;
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 3) == 0) begin
                level = 1'b0;
                hold  = $urandom_range(1, IDLE_MAX) - 1;
            end else begin
                level = 1'b1;
                hold  = $urandom_range(0, 11);
            end
            vertex_if.ready <= level;
        end
    end

    // Checker: every accepted vertex word against the oldest prediction.
    initial begin : vertex_check
        out_word_t got;
        out_word_t want;
        forever begin
            @(posedge clk);
            if (rst_n && vertex_if.valid && vertex_if.ready) begin
                got = vertex_if.data;
                if (expected_vertices.size() == 0) begin
                    note_failure("unexpected vertex word", '0, got);
                end else begin
                    want = expected_vertices.pop_front();
                    if (got.vertex_id      !== want.vertex_id      ||
                        got.is_new         !== want.is_new         ||
                        got.table_full     !== want.table_full     ||
                        got.distinct_count !== want.distinct_count ||
                        got.corners_seen   !== want.corners_seen)
                        note_failure("vertex word mismatch", want, got);
                end
            end
        end
    end

    // Hang guard.
    initial begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        corner_if.valid = 1'b0;
        corner_if.data  = '0;
        rst_n           = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_extremes();
        test_random_meshes(RANDOM_IDLE_CNT);

        // Last part runs with both sides streaming flat out.
        send_idle = 1'b0;
        sink_idle = 1'b0;
        test_random_meshes(RANDOM_BUSY_CNT);

        drain_results();
        // Let a stray late word show up, if there is one.
        repeat (TB_DEPTH + 8) @(negedge clk);

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/vtd_pkg.sv
hdl/vtd_stream_if.sv
hdl/vtd_ram.sv
hdl/vertex_triple_dedup_core.sv
hdl/vtd_checker.sv
bench/vertex_triple_dedup_core_tb.sv
